// ===== sv/dmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmpc_pkg
// Shared widths, codes and control types for the debounced pulse counter.
// ----------------------------------------------------------------------------
package dmpc_pkg;

    localparam int CHANNELS     = 8;
    localparam int HISTORY_BITS = 16;
    localparam int LEVEL_BITS   = 8;
    localparam int CMD_W        = 2;
    localparam int CHAN_W       = 4;
    localparam int COUNT_W      = 32;
    localparam int CFG_CNT_W    = 4;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL      = 2'd0,
        CMD_READ      = 2'd1,
        CMD_CLEAR_ONE = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT  = 1'd0,
        REG_INITIAL_LEVELS = 1'd1
    } t_cfg_reg;

    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic [LEVEL_BITS-1:0]   t_levels;
    typedef logic [HISTORY_BITS-1:0] t_history;

    // Per-channel control from the command decode.
    typedef struct packed {
        logic reload;      // reload history and pattern from init_level
        logic init_level;
        logic poll;        // shift in sample and check the pattern
        logic sample;
        logic clear;       // zero the count
    } t_chan_ctrl;

    // Level of a channel's line; channels without a bit read as low.
    function automatic logic level_bit(input t_levels levels, input int idx);
        t_levels sh;
        sh = levels >> idx;
        return sh[0];
    endfunction

endpackage

// ===== sv/dmpc_channel.sv =====
// ----------------------------------------------------------------------------
// dmpc_channel
// One channel: level history, pattern phase and wrapping edge count.
// ----------------------------------------------------------------------------
module dmpc_channel
    import dmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_ctrl i_ctrl,
    output t_count     o_count
);

    t_history r_hist, n_hist, w_shift, w_pattern;
    logic     r_phase, n_phase;
    t_count   r_count, n_count;

    // Phase low expects one-then-zeros (0..01), phase high zero-then-ones (1..10).
    assign w_pattern = {{(HISTORY_BITS-1){r_phase}}, ~r_phase};
    assign w_shift   = {r_hist[HISTORY_BITS-2:0], i_ctrl.sample};

    always_comb begin
        n_hist  = r_hist;
        n_phase = r_phase;
        n_count = r_count;
        if (i_ctrl.reload) begin
            n_hist  = {HISTORY_BITS{i_ctrl.init_level}};
            n_phase = i_ctrl.init_level;
        end else if (i_ctrl.poll) begin
            n_hist = w_shift;
            if (w_shift == w_pattern) begin
                n_count = r_count + t_count'(1);
                n_phase = ~r_phase;
            end
        end
        if (i_ctrl.clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_phase <= 1'b0;
            r_count <= '0;
        end else begin
            r_hist  <= n_hist;
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== sv/debounced_multi_channel_pulse_counter_core.sv =====
// ----------------------------------------------------------------------------
// debounced_multi_channel_pulse_counter_core
// Debounced edge counter over several encoder lines with poll/read/clear items.
// ----------------------------------------------------------------------------
// Each accepted item's result is registered in the result register, or in the skid while a result is
// held; state updates at the accept edge. Throughput: one item per cycle while ready is high; all
// channels update in parallel from flops. A two-entry output stage (result register plus skid) keeps input ready high
// for one stalled result; ready drops when both entries are full or in reset.
// Reset (synchronous, active low): registers zero, no channel enabled,
// histories zero, patterns one-then-zeros, counts zero, output empty.
// ----------------------------------------------------------------------------
module debounced_multi_channel_pulse_counter_core
    import dmpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [LEVEL_BITS-1:0] i_pin_levels,
    input  logic [CHAN_W-1:0]     i_channel,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_W-1:0]    o_tick_count,
    output logic                  o_channel_valid
);

    // ---------------- configuration registers ----------------
    logic [CFG_CNT_W-1:0] r_cfg_count, n_cfg_count;
    t_levels              r_init_levels, n_init_levels;

    // Any write reloads every history from the levels as they stand after it.
    always_comb begin
        n_cfg_count   = r_cfg_count;
        n_init_levels = r_init_levels;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_CHANNEL_COUNT:  n_cfg_count   = i_cfg_data[CFG_CNT_W-1:0];
                REG_INITIAL_LEVELS: n_init_levels = i_cfg_data[LEVEL_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count   <= '0;
            r_init_levels <= '0;
        end else begin
            r_cfg_count   <= n_cfg_count;
            r_init_levels <= n_init_levels;
        end
    end

    // ---------------- handshake ----------------
    logic w_accept, w_take;
    logic r_out_valid, r_skid_valid;

    // Hold ready low in reset so no item is taken and then dropped.
    assign o_in_ready = i_rst_n & ~r_skid_valid;
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_take     = r_out_valid & i_out_ready;

    // ---------------- command decode ----------------
    t_cmd                w_cmd;
    logic [CHANNELS-1:0] w_enabled;
    logic                w_chan_ok;
    t_count              w_sel_count;
    t_count              w_tick;
    t_count              w_counts [CHANNELS];
    t_chan_ctrl          w_ctrl   [CHANNELS];

    assign w_cmd = t_cmd'(i_cmd);

    // A count above CHANNELS saturates: the loop only covers real channels.
    assign w_chan_ok = (int'(i_channel) < int'(r_cfg_count)) && (int'(i_channel) < CHANNELS);

    always_comb begin
        w_sel_count = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_enabled[i] = int'(r_cfg_count) > i;
            w_ctrl[i].reload     = i_cfg_we;
            w_ctrl[i].init_level = level_bit(n_init_levels, i);
            w_ctrl[i].sample     = level_bit(i_pin_levels, i);
            w_ctrl[i].poll       = w_accept && (w_cmd == CMD_POLL) && w_enabled[i];
            // Clear-all touches only enabled channels; disabled counts survive.
            w_ctrl[i].clear      = w_accept && w_enabled[i]
                                 && ((w_cmd == CMD_CLEAR_ALL)
                                     || ((w_cmd == CMD_CLEAR_ONE) && (int'(i_channel) == i)));
            if (int'(i_channel) == i) begin
                w_sel_count = w_counts[i];
            end
        end
        w_tick = ((w_cmd == CMD_READ) && w_chan_ok) ? w_sel_count : '0;
    end

    // ---------------- channel array ----------------
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        dmpc_channel u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .o_count (w_counts[g])
        );
    end

    // ---------------- result register and skid ----------------
    t_count r_out_tick, r_skid_tick;
    logic   r_out_cv, r_skid_cv;

    // Refill the result register from the skid first, then from a new item;
    // park a new item in the skid while the result is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_tick <= r_skid_tick;
                r_out_cv   <= r_skid_cv;
            end else begin
                r_out_tick <= w_tick;
                r_out_cv   <= w_chan_ok;
            end
        end else if (w_accept) begin
            r_skid_tick <= w_tick;
            r_skid_cv   <= w_chan_ok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tick_count    = r_out_tick;
    assign o_channel_valid = r_out_cv;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while result register is empty");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("item accepted under stall was not parked");

    a_invalid_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_channel_valid) |-> (o_tick_count == '0))
        else $error("nonzero count for a disabled channel");

endmodule

// ===== tb/sv/debounced_multi_channel_pulse_counter_core_test.sv =====
// ----------------------------------------------------------------------------
// debounced_multi_channel_pulse_counter_core_test
// Self-checking bench for the debounced pulse counter. Drives poll, read and
// clear items through a valid/ready port, rewrites the channel setup between
// phases, and compares each result against an edge-count predictor kept here.
// ----------------------------------------------------------------------------
module debounced_multi_channel_pulse_counter_core_test
    import dmpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime HALF_PERIOD = 6.0;
    localparam int      RESET_CYCLES = 12;
    localparam int      CYCLE_LIMIT  = 250000;
    localparam int      PHASE_ITEMS  = 230;

    typedef struct {
        t_cmd                 cmd;
        t_levels              pins;
        logic [CHAN_W-1:0]    chan;
    } counter_item_t;

    typedef struct {
        t_count               ticks;
        logic                 chan_valid;
    } counter_result_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    t_cmd                  i_cmd           = CMD_POLL;
    t_levels               i_pin_levels    = '0;
    logic [CHAN_W-1:0]     i_channel       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    t_count                o_tick_count;
    logic                  o_channel_valid;

    debounced_multi_channel_pulse_counter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_pin_levels    (i_pin_levels),
        .i_channel       (i_channel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tick_count    (o_tick_count),
        .o_channel_valid (o_channel_valid)
    );

    // ------------------------------------------------------------------------
    // Clock, reset and run bookkeeping
    // ------------------------------------------------------------------------
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hold reset for a fixed number of edges, then release it for good.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    counter_item_t   pending_items[$];
    counter_result_t owed_results[$];
    counter_item_t   next_item;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Edge-count predictor: setup registers plus per-channel debounce state
    // ------------------------------------------------------------------------
    logic [CFG_CNT_W-1:0] chan_count_reg = '0;
    t_levels              init_levels_reg = '0;
    t_history             shift_hist [CHANNELS];
    t_history             edge_pattern [CHANNELS];
    t_count               edge_total [CHANNELS];

    // Lines above the level byte have no bit and read as low.
    function automatic logic line_bit(input t_levels levels, input int idx);
        return (idx < LEVEL_BITS) ? levels[idx] : 1'b0;
    endfunction

    function automatic int unsigned enabled_lines();
        return (chan_count_reg > CHANNELS) ? CHANNELS : chan_count_reg;
    endfunction

    // Any setup write restarts each history from its line's idle level.
    function automatic void reload_debounce();
        int i;
        for (i = 0; i < CHANNELS; i++) begin
            if (line_bit(init_levels_reg, i)) begin
                shift_hist[i]   = '1;
                edge_pattern[i] = ~t_history'(1);
            end else begin
                shift_hist[i]   = '0;
                edge_pattern[i] = t_history'(1);
            end
        end
    endfunction

    // Advance the debounce state for one accepted item and owe its result.
    function automatic void predict_item(input t_cmd cmd, input t_levels pins,
                                         input logic [CHAN_W-1:0] chan);
        int unsigned     n;
        int              i;
        counter_result_t res;
        n              = enabled_lines();
        res.chan_valid = (chan < n);
        res.ticks      = '0;
        case (cmd)
            CMD_POLL: begin
                for (i = 0; i < n; i++) begin
                    shift_hist[i] = {shift_hist[i][HISTORY_BITS-2:0], line_bit(pins, i)};
                    if (shift_hist[i] == edge_pattern[i]) begin
                        edge_total[i]   = edge_total[i] + 1'b1;
                        edge_pattern[i] = ~edge_pattern[i];
                    end
                end
            end
            CMD_READ: begin
                if (res.chan_valid)
                    res.ticks = edge_total[chan];
            end
            CMD_CLEAR_ONE: begin
                if (res.chan_valid)
                    edge_total[chan] = '0;
            end
            default: begin
                // Disabled channels keep their counts.
                for (i = 0; i < n; i++)
                    edge_total[i] = '0;
            end
        endcase
        owed_results.push_back(res);
    endfunction

    initial begin
        for (int i = 0; i < CHANNELS; i++)
            edge_total[i] = '0;
        reload_debounce();
    end

    // ------------------------------------------------------------------------
    // Driver: present queued items, predict on every accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_cmd, i_pin_levels, i_channel);
                accepted_total++;
            end
            // The slot is free if nothing is shown or the shown item just went.
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    i_cmd        <= next_item.cmd;
                    i_pin_levels <= next_item.pins;
                    i_channel    <= next_item.chan;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result, stall at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        counter_result_t want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = owed_results.pop_front();
                    if (o_tick_count !== want.ticks)
                        report_mismatch($sformatf("tick_count got %0h want %0h",
                                                  o_tick_count, want.ticks));
                    if (o_channel_valid !== want.chan_valid)
                        report_mismatch($sformatf("channel_valid got %0b want %0b",
                                                  o_channel_valid, want.chan_valid));
                end
            end
            i_out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_levels wire_level = '0;   // clean level of each encoder line

    function automatic void queue_item(input t_cmd cmd, input t_levels pins,
                                       input logic [CHAN_W-1:0] chan);
        counter_item_t it;
        it.cmd  = cmd;
        it.pins = pins;
        it.chan = chan;
        pending_items.push_back(it);
        queued_total++;
    endfunction

    // Mostly an index inside the channel array, now and then one beyond it, up to 15.
    function automatic logic [CHAN_W-1:0] pick_channel();
        return ($urandom_range(9, 0) < 8) ? CHAN_W'($urandom_range(CHANNELS - 1, 0))
                                          : CHAN_W'($urandom_range(15, CHANNELS));
    endfunction

    // Lines that flip now and then and hold long enough to debounce, with
    // single-sample glitches and some fully random samples mixed in.
    function automatic void queue_polls(input int n);
        t_levels glitch;
        int      k;
        int      b;
        for (k = 0; k < n; k++) begin
            glitch = '0;
            for (b = 0; b < LEVEL_BITS; b++) begin
                if ($urandom_range(27, 0) == 0)
                    wire_level[b] = ~wire_level[b];
                if ($urandom_range(39, 0) == 0)
                    glitch[b] = 1'b1;
            end
            if ($urandom_range(9, 0) == 0)
                queue_item(CMD_POLL, t_levels'($urandom()), pick_channel());
            else
                queue_item(CMD_POLL, wire_level ^ glitch, pick_channel());
        end
    endfunction

    // Bursts of polls followed by a few reads and clears.
    function automatic void queue_traffic(input int n_items);
        int start;
        int j;
        int sel;
        start = queued_total;
        while (queued_total - start < n_items) begin
            queue_polls($urandom_range(60, 8));
            for (j = $urandom_range(4, 1); j > 0; j--) begin
                sel = $urandom_range(99, 0);
                if (sel < 75)
                    queue_item(CMD_READ, t_levels'($urandom()), pick_channel());
                else if (sel < 94)
                    queue_item(CMD_CLEAR_ONE, t_levels'($urandom()), pick_channel());
                else
                    queue_item(CMD_CLEAR_ALL, t_levels'($urandom()), pick_channel());
            end
        end
    endfunction

    // Wait until every queued item is in and every result is out, then
    // let the result register and skid drain a little more.
    task automatic settle();
        while (accepted_total != queued_total || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // The block takes the write at this edge; mirror it.
        if (which == REG_CHANNEL_COUNT)
            chan_count_reg = data[CFG_CNT_W-1:0];
        else
            init_levels_reg = data;
        reload_debounce();
    endtask

    // Write both registers in random order; upper count bits carry junk.
    task automatic set_channels(input logic [CFG_CNT_W-1:0] cnt, input t_levels lvl);
        logic [CFG_DATA_W-1:0] cnt_word;
        cnt_word = {4'($urandom()), cnt};
        if ($urandom_range(1, 0)) begin
            write_reg(REG_CHANNEL_COUNT, cnt_word);
            write_reg(REG_INITIAL_LEVELS, lvl);
        end else begin
            write_reg(REG_INITIAL_LEVELS, lvl);
            write_reg(REG_CHANNEL_COUNT, cnt_word);
        end
        wire_level = lvl;
    endtask

    logic [CFG_CNT_W-1:0] phase_cnt [8] = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd8, 4'd5, 4'd1, 4'd0};
    t_levels              phase_lvl [8] = '{8'h00, 8'hFF, 8'h5A, 8'h33, 8'hFF, 8'h00, 8'h00, 8'h00};

    initial begin
        @(posedge i_clk iff i_rst_n);

        // Nothing enabled after reset: every channel reads as invalid.
        queue_item(CMD_READ,      8'h00, 4'd0);
        queue_item(CMD_READ,      8'hFF, 4'd15);
        queue_item(CMD_POLL,      8'hFF, 4'd0);
        queue_item(CMD_POLL,      8'h00, 4'd7);
        queue_item(CMD_CLEAR_ONE, 8'h00, 4'd0);
        queue_item(CMD_CLEAR_ALL, 8'hFF, 4'd15);
        settle();

        // Over-range count saturates; one inverted poll edges every line.
        set_channels(4'd15, 8'hA5);
        queue_item(CMD_POLL,      8'h5A, 4'd0);
        queue_item(CMD_READ,      8'h00, 4'd0);
        queue_item(CMD_READ,      8'h00, 4'd7);
        queue_item(CMD_READ,      8'h00, 4'd8);
        queue_item(CMD_READ,      8'h00, 4'd15);
        queue_item(CMD_CLEAR_ONE, 8'h00, 4'd3);
        queue_item(CMD_READ,      8'h00, 4'd3);
        queue_item(CMD_CLEAR_ONE, 8'h00, 4'd12);
        queue_item(CMD_READ,      8'h00, 4'd4);
        queue_item(CMD_CLEAR_ALL, 8'h00, 4'd0);
        queue_item(CMD_READ,      8'h00, 4'd1);
        queue_item(CMD_POLL,      8'hFF, 4'd0);
        queue_item(CMD_POLL,      8'h00, 4'd0);
        queue_item(CMD_READ,      8'h00, 4'd6);
        settle();

        // Random traffic: two setups per idling mix, no idling first.
        phase_lvl[5] = t_levels'($urandom());
        phase_lvl[6] = t_levels'($urandom());
        phase_lvl[7] = t_levels'($urandom());
        phase_cnt[7] = CFG_CNT_W'($urandom_range(15, 0));
        for (int p = 0; p < 8; p++) begin
            case (p / 2)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            set_channels(phase_cnt[p], phase_lvl[p]);
            queue_traffic(PHASE_ITEMS);
            settle();
        end

        if (owed_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
